[hw/rtl/apbu_pkg.sv]
// Shared types and constants for the ARGB pixel blend unit.
package apbu_pkg;

	localparam int unsigned PIXEL_W = 32;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned REG_INDEX_W = 2;
	localparam logic [CHAN_W-1:0] FULL_LEVEL = 8'hFF;
	localparam logic [PIXEL_W-1:0] FILL_COLOR_RESET = 32'hFFFF_FFFF;
	localparam logic [CHAN_W-1:0] MASK_SCALE_RESET = 8'h01;

	typedef enum logic [1:0] {
		MODE_COPY = 2'd0,
		MODE_BLEND = 2'd1,
		MODE_MASK_BLEND = 2'd2,
		MODE_MASK_FILL = 2'd3
	} blend_mode_t;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_BLEND_MODE = 2'd0,
		REG_FILL_COLOR = 2'd1,
		REG_MASK_SCALE = 2'd2,
		REG_UNUSED = 2'd3
	} reg_index_t;

	typedef struct packed {
		blend_mode_t mode;
		logic [PIXEL_W-1:0] dest;
		logic [PIXEL_W-1:0] src;
		logic [CHAN_W-1:0] mask;
	} item_t;

endpackage

[hw/rtl/argb_pixel_blend_unit_core.sv]
// Top level of the ARGB pixel blend unit: configuration registers and stage wiring.
//
// Usage: each input transfer (in_valid high, in_stall low) carries a destination
// pixel and a source value; each output transfer delivers one ARGB8888 pixel to
// write back, in input order.
// The configuration port writes blend_mode, fill_color and mask_scale at index 0,
// 1 and 2 on any edge with wr_en high. Write it only while no pixels are in flight.
// An input pixel passes through the front register, the queue and the back stages in order.
// Throughput is one pixel per cycle while out_stall stays low, set by the front
// register, a four-entry queue and two back stages that each take a pixel every cycle.
// When the receiver raises out_stall, the output register holds its pixel, the
// back stages and the queue fill, and in_stall rises once the front register
// can no longer hand its pixel to the queue.
// Reset clears all valid flags and the queue, and sets blend_mode to copy,
// fill_color to opaque white and mask_scale to one.
module argb_pixel_blend_unit_core (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [apbu_pkg::REG_INDEX_W-1:0] wr_index,
	input  logic [apbu_pkg::PIXEL_W-1:0] wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [apbu_pkg::PIXEL_W-1:0] dest_pixel,
	input  logic [apbu_pkg::PIXEL_W-1:0] source_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [apbu_pkg::PIXEL_W-1:0] out_pixel
);

	apbu_pkg::blend_mode_t mode_q;
	logic [apbu_pkg::PIXEL_W-1:0] fill_color_q;
	logic [apbu_pkg::CHAN_W-1:0] mask_scale_q;
	logic push;
	logic pop;
	logic queue_full;
	logic not_empty;
	apbu_pkg::item_t push_item;
	apbu_pkg::item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= apbu_pkg::MODE_COPY;
			fill_color_q <= apbu_pkg::FILL_COLOR_RESET;
			mask_scale_q <= apbu_pkg::MASK_SCALE_RESET;
		end else if (wr_en) begin
			unique case (apbu_pkg::reg_index_t'(wr_index))
				apbu_pkg::REG_BLEND_MODE: mode_q <= apbu_pkg::blend_mode_t'(wr_data[1:0]);
				apbu_pkg::REG_FILL_COLOR: fill_color_q <= wr_data;
				apbu_pkg::REG_MASK_SCALE: mask_scale_q <= wr_data[apbu_pkg::CHAN_W-1:0];
				default: mode_q <= mode_q;
			endcase
		end
	end

	apbu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.dest_pixel(dest_pixel),
		.source_value(source_value),
		.mode(mode_q),
		.fill_color(fill_color_q),
		.mask_scale(mask_scale_q),
		.push(push),
		.push_item(push_item),
		.queue_full(queue_full)
	);

	apbu_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(queue_full),
		.pop(pop),
		.not_empty(not_empty),
		.pop_item(pop_item)
	);

	apbu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.not_empty(not_empty),
		.pop_item(pop_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_pixel(out_pixel)
	);

endmodule

[hw/rtl/apbu_front.sv]
// Front stage: accepts pixels, selects the source color and scales the mask level.
module apbu_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [apbu_pkg::PIXEL_W-1:0] dest_pixel,
	input  logic [apbu_pkg::PIXEL_W-1:0] source_value,
	input  apbu_pkg::blend_mode_t mode,
	input  logic [apbu_pkg::PIXEL_W-1:0] fill_color,
	input  logic [apbu_pkg::CHAN_W-1:0] mask_scale,
	output logic push,
	output apbu_pkg::item_t push_item,
	input  logic queue_full
);

	logic vld_s1;
	apbu_pkg::item_t item_s1;
	apbu_pkg::item_t item_d;
	logic [2*apbu_pkg::CHAN_W-1:0] mask_prod;
	logic adv;

	assign adv = !vld_s1 || !queue_full;
	assign in_stall = !adv;
	assign push = vld_s1 && !queue_full;
	assign push_item = item_s1;

	always_comb begin
		mask_prod = source_value[apbu_pkg::CHAN_W-1:0] * mask_scale;
		item_d.mode = mode;
		item_d.dest = dest_pixel;
		item_d.mask = (|mask_prod[2*apbu_pkg::CHAN_W-1:apbu_pkg::CHAN_W]) ?
			apbu_pkg::FULL_LEVEL : mask_prod[apbu_pkg::CHAN_W-1:0];
		unique case (mode)
			apbu_pkg::MODE_MASK_BLEND, apbu_pkg::MODE_MASK_FILL: item_d.src = fill_color;
			default: item_d.src = source_value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

[hw/rtl/apbu_fifo.sv]
// Four-entry queue between the front and back stages.
module apbu_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  apbu_pkg::item_t push_item,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output apbu_pkg::item_t pop_item
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	apbu_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign full = (count_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/apbu_back.sv]
// Back stages: alpha rule, per-channel mix and the output register.
module apbu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic not_empty,
	input  apbu_pkg::item_t pop_item,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [apbu_pkg::PIXEL_W-1:0] out_pixel
);

	localparam int unsigned CW = apbu_pkg::CHAN_W;

	logic vld_s1;
	logic vld_s2;
	logic en1;
	logic en2;
	apbu_pkg::blend_mode_t mode_s1;
	logic [apbu_pkg::PIXEL_W-1:0] dest_s1;
	logic [apbu_pkg::PIXEL_W-1:0] src_s1;
	logic [CW-1:0] weight_s1;
	logic [CW-1:0] oalpha_s1;
	logic [CW-1:0] malpha_s1;
	logic [apbu_pkg::PIXEL_W-1:0] pixel_s2;

	logic [CW-1:0] da;
	logic [CW-1:0] sa;
	logic [CW-1:0] fa;
	logic [2*CW-1:0] ma_prod;
	logic [CW-1:0] ma;
	logic [CW:0] asum;
	logic [CW-1:0] weight_d;
	logic [CW-1:0] oalpha_d;
	logic [apbu_pkg::PIXEL_W-1:0] mixed;
	logic [apbu_pkg::PIXEL_W-1:0] pixel_d;

	function automatic logic [CW-1:0] mix_chan(input logic [CW-1:0] dc,
			input logic [CW-1:0] sc, input logic [CW-1:0] a);
		logic [2*CW:0] acc;
		acc = (2*CW+1)'(dc * (apbu_pkg::FULL_LEVEL - a)) + (2*CW+1)'(sc * a);
		return acc[2*CW-1:CW];
	endfunction

	assign en2 = !vld_s2 || !out_stall;
	assign en1 = !vld_s1 || en2;
	assign pop = not_empty && en1;
	assign out_valid = vld_s2;
	assign out_pixel = pixel_s2;

	always_comb begin
		da = pop_item.dest[apbu_pkg::PIXEL_W-1 -: CW];
		sa = pop_item.src[apbu_pkg::PIXEL_W-1 -: CW];
		fa = sa;
		ma_prod = pop_item.mask * fa;
		ma = ma_prod[2*CW-1:CW];
		weight_d = sa;
		asum = {1'b0, da} + {1'b0, sa};
		if (pop_item.mode == apbu_pkg::MODE_MASK_BLEND) begin
			asum = {1'b0, da} + {1'b0, ma};
			weight_d = (pop_item.mask == '0) ? '0 : ma;
		end
		if (da == '0) begin
			weight_d = apbu_pkg::FULL_LEVEL;
		end
		oalpha_d = asum[CW] ? apbu_pkg::FULL_LEVEL : asum[CW-1:0];
	end

	always_comb begin
		mixed[apbu_pkg::PIXEL_W-1 -: CW] = oalpha_s1;
		for (int i = 0; i < 3; i++) begin
			mixed[i*CW +: CW] = mix_chan(dest_s1[i*CW +: CW], src_s1[i*CW +: CW], weight_s1);
		end
		unique case (mode_s1)
			apbu_pkg::MODE_COPY: pixel_d = src_s1;
			apbu_pkg::MODE_MASK_FILL: pixel_d = {malpha_s1, src_s1[apbu_pkg::PIXEL_W-CW-1:0]};
			default: pixel_d = mixed;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= not_empty;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_s1 <= pop_item.mode;
			dest_s1 <= pop_item.dest;
			src_s1 <= pop_item.src;
			weight_s1 <= weight_d;
			oalpha_s1 <= oalpha_d;
			malpha_s1 <= ma;
		end
		if (en2 && vld_s1) begin
			pixel_s2 <= pixel_d;
		end
	end

endmodule
